@@ src/rbd_pkg.sv @@
package rbd_pkg;

	// Default sizing, handed down from the top level as parameters.
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int VALUE_BITS_DEF = 16;

	// Fixed port widths.
	localparam int PIX_BITS      = 16;
	localparam int FW_BITS       = 11;
	localparam int FH_BITS       = 16;
	localparam int MODE_BITS     = 2;
	localparam int CODE_BITS     = 2;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_MODE    = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_USE_EIGHT    = 2'd3;

	// Register reset values.
	localparam logic [FW_BITS-1:0]   FRAME_WIDTH_RST  = 11'd1024;
	localparam logic [FH_BITS-1:0]   FRAME_HEIGHT_RST = 16'd1;
	localparam logic [MODE_BITS-1:0] EDGE_MODE_RST    = 2'd0;

	// Edge modes. Any mode with the upper bit set is class change mode.
	localparam logic [MODE_BITS-1:0] MODE_INNER = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_OUTER = 2'd1;

	// Result codes.
	localparam logic [CODE_BITS-1:0] CODE_NO_DATA  = 2'd0;
	localparam logic [CODE_BITS-1:0] CODE_INTERIOR = 2'd1;
	localparam logic [CODE_BITS-1:0] CODE_EDGE     = 2'd2;

	// Flattened 3x3 positions (row * 3 + col) of the neighbours, in the order
	// up, left, right, down, then the four diagonals.
	localparam logic [3:0] NB_POS [8] = '{4'd1, 4'd3, 4'd5, 4'd7, 4'd0, 4'd2, 4'd6, 4'd8};

	// Result queue between the front and back parts.
	localparam int MAX_RESULTS = 4;
	localparam int RUN_N_BITS  = 3;
	localparam int QDEPTH      = 4;
	localparam int QPTR_BITS   = $clog2(QDEPTH);
	localparam int QL_BITS     = $clog2(QDEPTH + 1);

	// Position of one pixel in the frame, decoded at acceptance.
	typedef struct packed {
		logic r_ge1;
		logic r_is0;
		logic r_is1;
		logic last_row;
		logic c_ge1;
		logic c_is0;
		logic c_is1;
		logic last_col;
	} pos_t;

	// All results caused by one pixel, packed from slot 0.
	typedef struct packed {
		logic [RUN_N_BITS-1:0]                    n;
		logic [MAX_RESULTS-1:0][CODE_BITS-1:0]    codes;
	} run_t;

endpackage

@@ src/raster_boundary_detect_3x3_top.sv @@
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// input    | in_valid / in_stall       | pixel_value[15:0], no_data
// output   | out_valid / out_stall     | edge_code[1:0], last_of_run
// config   | cfg_we, cfg_index[1:0]    | cfg_data[15:0] (no wait, no read-back)
//
// One pixel transaction can be taken every cycle while in_stall is low. Its
// results go through the line buffer read, then the window update and
// classification, then enter the result queue and are offered from there.
// Results leave one per cycle while out_stall is low, so the output port sets
// the sustained rate: a pixel causes none on the first column of a row or on the
// first row of a taller frame, one inside the frame, two at a row end or on the
// last row, and up to four on the last pixel of a frame. The four-entry result
// queue only absorbs these bursts. Reset clears counters, window and queue; the
// line buffer has no clearing pass. Either side may stall at any time without
// loss; in_stall rises when the queue and the two stages in flight could fill it.
module raster_boundary_detect_3x3_top #(
	parameter int MAX_WIDTH  = rbd_pkg::MAX_WIDTH_DEF,
	parameter int VALUE_BITS = rbd_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rbd_pkg::PIX_BITS-1:0]      pixel_value,
	input  logic                              no_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rbd_pkg::CODE_BITS-1:0]     edge_code,
	output logic                              last_of_run,
	input  logic                              cfg_we,
	input  logic [rbd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [rbd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	// Configuration registers. The user must see that they are only written while
	// the block is idle, so every stage can read them directly; the block does not enforce it.
	logic [rbd_pkg::FW_BITS-1:0]   frame_width_q;
	logic [rbd_pkg::FH_BITS-1:0]   frame_height_q;
	logic [rbd_pkg::MODE_BITS-1:0] edge_mode_q;
	logic                          use_eight_q;

	// Front to queue to back.
	logic                          push;
	rbd_pkg::run_t                 push_run;
	logic                          pop;
	logic                          not_empty;
	rbd_pkg::run_t                 head;
	logic [rbd_pkg::QL_BITS-1:0]   q_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= rbd_pkg::FRAME_WIDTH_RST;
			frame_height_q <= rbd_pkg::FRAME_HEIGHT_RST;
			edge_mode_q    <= rbd_pkg::EDGE_MODE_RST;
			use_eight_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				rbd_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[rbd_pkg::FW_BITS-1:0];
				rbd_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[rbd_pkg::FH_BITS-1:0];
				rbd_pkg::REG_EDGE_MODE:    edge_mode_q    <= cfg_data[rbd_pkg::MODE_BITS-1:0];
				rbd_pkg::REG_USE_EIGHT:    use_eight_q    <= cfg_data[0];
				default:                   use_eight_q    <= use_eight_q;
			endcase
		end
	end

	// The front keeps the position counters, the line buffer and the 3x3 window,
	// and classifies every result a pixel causes in one go.
	rbd_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.pixel_value         (pixel_value),
		.no_data             (no_data),
		.frame_width         (frame_width_q),
		.frame_height        (frame_height_q),
		.edge_mode           (edge_mode_q),
		.use_eight_neighbours(use_eight_q),
		.q_level             (q_level),
		.push                (push),
		.push_run            (push_run)
	);

	// The queue holds one entry per pixel that caused results.
	rbd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.not_empty(not_empty),
		.head     (head),
		.level    (q_level)
	);

	// The back part hands out the results of the head entry in order and marks
	// the last one of each pixel.
	rbd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (not_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.edge_code  (edge_code),
		.last_of_run(last_of_run)
	);

endmodule

@@ src/rbd_ram.sv @@
module rbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/rbd_front.sv @@
module rbd_front #(
	parameter int MAX_WIDTH  = rbd_pkg::MAX_WIDTH_DEF,
	parameter int VALUE_BITS = rbd_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rbd_pkg::PIX_BITS-1:0]    pixel_value,
	input  logic                            no_data,
	input  logic [rbd_pkg::FW_BITS-1:0]     frame_width,
	input  logic [rbd_pkg::FH_BITS-1:0]     frame_height,
	input  logic [rbd_pkg::MODE_BITS-1:0]   edge_mode,
	input  logic                            use_eight_neighbours,
	input  logic [rbd_pkg::QL_BITS-1:0]     q_level,
	output logic                            push,
	output rbd_pkg::run_t                   push_run
);

	localparam int CW       = $clog2(MAX_WIDTH);
	localparam int EWN      = $clog2(MAX_WIDTH + 1);
	localparam int EW_BITS  = (rbd_pkg::FW_BITS > EWN) ? rbd_pkg::FW_BITS : EWN;
	localparam int CELL_W   = VALUE_BITS + 1;
	localparam int SUM_BITS = rbd_pkg::QL_BITS + 1;

	typedef logic [CELL_W-1:0] cell_t;
	typedef cell_t [8:0] hood_t;
	typedef cell_t [2:0][2:0] win_t;

	// Cell layout: no-data flag on top, class value below.
	function automatic hood_t gather(win_t w, logic lower, logic top_edge, logic at_cur,
			logic left_edge);
		logic [1:0] rs [3];
		logic [1:0] cs [3];
		hood_t h;
		rs[0] = lower ? 2'd1 : 2'd0;
		rs[1] = lower ? 2'd2 : 2'd1;
		rs[2] = 2'd2;
		if (top_edge) begin
			rs[0] = rs[1];
		end
		cs[0] = at_cur ? 2'd1 : 2'd0;
		cs[1] = at_cur ? 2'd2 : 2'd1;
		cs[2] = 2'd2;
		if (left_edge) begin
			cs[0] = cs[1];
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				h[i * 3 + j] = w[rs[i]][cs[j]];
			end
		end
		return h;
	endfunction

	function automatic logic [rbd_pkg::CODE_BITS-1:0] classify(hood_t h,
			logic [rbd_pkg::MODE_BITS-1:0] mode, logic use8);
		cell_t ctr;
		cell_t rf;
		cell_t v;
		logic  any_nd;
		logic  any_ok;
		logic  any_diff;
		logic [rbd_pkg::CODE_BITS-1:0] code;
		ctr      = h[4];
		rf       = h[rbd_pkg::NB_POS[0]];
		any_nd   = 1'b0;
		any_ok   = 1'b0;
		any_diff = 1'b0;
		for (int k = 0; k < 8; k++) begin
			v = h[rbd_pkg::NB_POS[k]];
			if (k < 4 || use8) begin
				any_nd = any_nd | v[VALUE_BITS];
				any_ok = any_ok | ~v[VALUE_BITS];
				if (k != 0) begin
					if (rf[VALUE_BITS]) begin
						any_diff = any_diff | ~v[VALUE_BITS];
					end else begin
						any_diff = any_diff | v[VALUE_BITS]
							| (v[VALUE_BITS-1:0] != rf[VALUE_BITS-1:0]);
					end
				end
			end
		end
		case (mode)
			rbd_pkg::MODE_INNER: begin
				if (ctr[VALUE_BITS]) begin
					code = rbd_pkg::CODE_NO_DATA;
				end else begin
					code = any_nd ? rbd_pkg::CODE_EDGE : rbd_pkg::CODE_INTERIOR;
				end
			end
			rbd_pkg::MODE_OUTER: begin
				if (!ctr[VALUE_BITS]) begin
					code = rbd_pkg::CODE_INTERIOR;
				end else begin
					code = any_ok ? rbd_pkg::CODE_EDGE : rbd_pkg::CODE_NO_DATA;
				end
			end
			default: begin
				if (any_diff) begin
					code = rbd_pkg::CODE_EDGE;
				end else begin
					code = rf[VALUE_BITS] ? rbd_pkg::CODE_NO_DATA : rbd_pkg::CODE_INTERIOR;
				end
			end
		endcase
		return code;
	endfunction

	// Acceptance and position counters.
	logic                acc;
	logic [CW-1:0]       col_q;
	logic [15:0]         row_q;
	logic [EW_BITS-1:0]  fw_ext;
	logic [EW_BITS-1:0]  ew_m1;
	logic [15:0]         eh_m1;
	rbd_pkg::pos_t       pos;
	logic [VALUE_BITS-1:0] px_val;
	cell_t               px_cell;
	logic [SUM_BITS-1:0] in_flight;

	// Stage 1: line buffer data arrives.
	logic                v_s1;
	rbd_pkg::pos_t       pos_s1;
	cell_t               px_s1;
	logic [CW-1:0]       addr_s1;
	logic                fwd_s1;
	cell_t               fwd_older_s1;
	cell_t               fwd_newer_s1;
	logic [2*CELL_W-1:0] rd_data;
	cell_t               up2;
	cell_t               up1;

	// Stage 2: window settled, results classified.
	logic                v_s2;
	rbd_pkg::pos_t       pos_s2;
	win_t                win_q;
	logic [rbd_pkg::MAX_RESULTS-1:0] mask;
	logic [rbd_pkg::MAX_RESULTS-1:0][rbd_pkg::CODE_BITS-1:0] codes;
	rbd_pkg::run_t       run;

	if (VALUE_BITS <= rbd_pkg::PIX_BITS) begin : g_val_narrow
		assign px_val = pixel_value[VALUE_BITS-1:0];
	end else begin : g_val_wide
		assign px_val = {{(VALUE_BITS - rbd_pkg::PIX_BITS){1'b0}}, pixel_value};
	end

	assign px_cell = {no_data, px_val};

	// Room in the queue is reserved for every pixel still in the two stages.
	assign in_flight = SUM_BITS'(q_level) + SUM_BITS'(v_s1) + SUM_BITS'(v_s2);
	assign in_stall  = in_flight >= SUM_BITS'(rbd_pkg::QDEPTH);
	assign acc       = in_valid && !in_stall;

	assign fw_ext = EW_BITS'(frame_width);

	always_comb begin
		if (frame_width == '0) begin
			ew_m1 = '0;
		end else if (fw_ext > EW_BITS'(MAX_WIDTH)) begin
			ew_m1 = EW_BITS'(MAX_WIDTH - 1);
		end else begin
			ew_m1 = fw_ext - EW_BITS'(1);
		end
		eh_m1 = (frame_height == '0) ? 16'd0 : frame_height - 16'd1;

		pos.r_ge1    = row_q != 16'd0;
		pos.r_is0    = row_q == 16'd0;
		pos.r_is1    = row_q == 16'd1;
		pos.last_row = row_q >= eh_m1;
		pos.c_ge1    = col_q != '0;
		pos.c_is0    = col_q == '0;
		pos.c_is1    = col_q == CW'(1);
		pos.last_col = EW_BITS'(col_q) >= ew_m1;
	end

	rbd_ram #(
		.WIDTH(2 * CELL_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (v_s1),
		.waddr(addr_s1),
		.wdata({up1, px_s1}),
		.re   (acc),
		.raddr(col_q),
		.rdata(rd_data)
	);

	// Width-one rows hit the same column on consecutive pixels; the pixel in
	// stage 1 then writes the column in the same edge the next one reads it.
	assign up2 = fwd_s1 ? fwd_older_s1 : rd_data[2*CELL_W-1:CELL_W];
	assign up1 = fwd_s1 ? fwd_newer_s1 : rd_data[CELL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			win_q <= '0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			if (acc) begin
				if (pos.last_col) begin
					col_q <= '0;
					row_q <= pos.last_row ? 16'd0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (v_s1) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= up2;
				win_q[1][2] <= up1;
				win_q[2][2] <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pos_s1       <= pos;
			px_s1        <= px_cell;
			addr_s1      <= col_q;
			fwd_s1       <= v_s1 && (addr_s1 == col_q);
			fwd_older_s1 <= up1;
			fwd_newer_s1 <= px_s1;
		end
		if (v_s1) begin
			pos_s2 <= pos_s1;
		end
	end

	// Up to four results per pixel: the row above (earlier column, then the
	// current column at the row end), then the current row on the last row.
	always_comb begin
		mask[0]  = pos_s2.r_ge1 & pos_s2.c_ge1;
		codes[0] = classify(gather(win_q, 1'b0, pos_s2.r_is1, 1'b0, pos_s2.c_is1),
			edge_mode, use_eight_neighbours);
		mask[1]  = pos_s2.r_ge1 & pos_s2.last_col;
		codes[1] = classify(gather(win_q, 1'b0, pos_s2.r_is1, 1'b1, pos_s2.c_is0),
			edge_mode, use_eight_neighbours);
		mask[2]  = pos_s2.last_row & pos_s2.c_ge1;
		codes[2] = classify(gather(win_q, 1'b1, pos_s2.r_is0, 1'b0, pos_s2.c_is1),
			edge_mode, use_eight_neighbours);
		mask[3]  = pos_s2.last_row & pos_s2.last_col;
		codes[3] = classify(gather(win_q, 1'b1, pos_s2.r_is0, 1'b1, pos_s2.c_is0),
			edge_mode, use_eight_neighbours);

		run = '0;
		for (int k = 0; k < rbd_pkg::MAX_RESULTS; k++) begin
			if (mask[k]) begin
				run.codes[run.n[1:0]] = codes[k];
				run.n = run.n + rbd_pkg::RUN_N_BITS'(1);
			end
		end
	end

	assign push     = v_s2 && (run.n != '0);
	assign push_run = run;

endmodule

@@ src/rbd_fifo.sv @@
module rbd_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  rbd_pkg::run_t               push_run,
	input  logic                        pop,
	output logic                        not_empty,
	output rbd_pkg::run_t               head,
	output logic [rbd_pkg::QL_BITS-1:0] level
);

	rbd_pkg::run_t                  entry_q [rbd_pkg::QDEPTH];
	logic [rbd_pkg::QPTR_BITS-1:0]  wr_ptr_q;
	logic [rbd_pkg::QPTR_BITS-1:0]  rd_ptr_q;
	logic [rbd_pkg::QL_BITS-1:0]    count_q;

	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_ptr_q];
	assign level     = count_q;

	// The front never pushes into a full queue: it reserves room on accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rbd_pkg::QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + rbd_pkg::QPTR_BITS'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + rbd_pkg::QL_BITS'(1);
				2'b01:   count_q <= count_q - rbd_pkg::QL_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_run;
		end
	end

endmodule

@@ src/rbd_back.sv @@
module rbd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          not_empty,
	input  rbd_pkg::run_t                 head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rbd_pkg::CODE_BITS-1:0] edge_code,
	output logic                          last_of_run
);

	localparam int IDX_BITS = $clog2(rbd_pkg::MAX_RESULTS);

	logic [IDX_BITS-1:0] idx_q;
	logic                take;

	assign out_valid   = not_empty;
	assign edge_code   = head.codes[idx_q];
	assign last_of_run = rbd_pkg::RUN_N_BITS'(idx_q) == head.n - rbd_pkg::RUN_N_BITS'(1);
	assign take        = out_valid && !out_stall;
	assign pop         = take && last_of_run;

	// Walks the results of the head entry, one per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= last_of_run ? '0 : idx_q + IDX_BITS'(1);
		end
	end

endmodule
